// ===== rtl/ps2mpc_pkg.sv =====
// Package for the PS/2 mouse packet cursor: widths, codes, item types and reset values.
package ps2mpc_pkg;

    // Cursor coordinate width and the width of a screen size register
    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Largest screen size the coordinates can address
    localparam logic [SIZE_BITS-1:0] COORD_SPAN = SIZE_BITS'(1 << COORD_BITS);

    // Screen size after reset and the matching centered cursor
    localparam logic [SIZE_BITS-1:0]  RESET_WIDTH  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0]  RESET_HEIGHT = SIZE_BITS'(480);
    localparam logic [COORD_BITS-1:0] RESET_POS_X  = COORD_BITS'(640 / 2);
    localparam logic [COORD_BITS-1:0] RESET_POS_Y  = COORD_BITS'(480 / 2);

    // Register indexes on the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Packet header bits
    localparam int SYNC_BIT  = 3;
    localparam int LEFT_BIT  = 0;
    localparam int RIGHT_BIT = 1;
    localparam logic [7:0] OVF_MASK = 8'hC0;

    // Event codes
    localparam logic [1:0] EV_MOVE = 2'd0;
    localparam logic [1:0] EV_DOWN = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    // Button codes
    localparam logic BTN_LEFT  = 1'b0;
    localparam logic BTN_RIGHT = 1'b1;

    // Position within a 3-byte packet
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       aux_flag;
        logic [7:0] data_byte;
    } ps2m_in_t;

    typedef struct packed {
        logic [1:0]            event_kind;
        logic                  which_button;
        logic [COORD_BITS-1:0] cursor_x;
        logic [COORD_BITS-1:0] cursor_y;
        logic                  last_event;
    } ps2m_out_t;

endpackage

// ===== rtl/ps2_mouse_packet_cursor.sv =====
// PS/2 mouse packet decoder with clamped cursor tracking and button events.
//
// Input channel (s_valid/s_ready/s_item): one controller byte per item with its
// auxiliary-port flag. Bytes without the flag are dropped. Three-byte packets
// are assembled; a header byte without bit 3 or with overflow bits set is
// discarded to resynchronize.
// Result channel (m_valid/m_ready/m_item): on the third byte of a packet the
// block emits a move event (if the position changed), then left and right
// button down/up events (each if that button changed), in that order;
// last_event marks the final one. An item is registered at acceptance and
// decoded into the event buffer once that buffer is free.
// Throughput: one item per cycle while the event buffer is free; a packet
// with k events holds the buffer until its last one leaves, one event per
// cycle while m_ready is high; the next item waits in the input register.
// When the receiver stalls, the event buffer holds and s_ready drops once the
// input register is full. Reset (aresetn low, synchronous) empties both
// stages, sets the screen to 640x480 and centers the cursor. Writing a size
// register over the APB port re-centers the cursor on both axes.
module ps2_mouse_packet_cursor
    import ps2mpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  ps2m_in_t          s_item,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output ps2m_out_t         m_item,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Registers
    logic                  in_valid_reg;
    ps2m_in_t              in_reg;
    logic [SIZE_BITS-1:0]  width_reg, width_next;
    logic [SIZE_BITS-1:0]  height_reg, height_next;
    phase_t                phase_reg, phase_next;
    logic [7:0]            first_reg, first_next;
    logic [7:0]            second_reg, second_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  prev_l_reg, prev_l_next;
    logic                  prev_r_reg, prev_r_next;
    // pending events: bit 0 move, bit 1 left, bit 2 right
    logic [2:0]            pend_reg, pend_next;
    logic [1:0]            kind_l_reg, kind_l_next;
    logic [1:0]            kind_r_reg, kind_r_next;

    logic                  cfg_wr;
    logic                  s_take, m_take;
    logic                  buf_free, proc_go;
    logic [SIZE_BITS-1:0]  eff_w, eff_h, eff_w_m1, eff_h_m1;
    logic [COORD_BITS-1:0] max_x, max_y, nx, ny;
    logic signed [COORD_BITS+1:0] sum_x, sum_y, move_b1, move_b2;
    logic                  cl, cr;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        prdata = '0;
        if (psel && !pwrite) begin
            prdata = (paddr[2] == REG_HEIGHT) ? APB_DW'(height_reg) : APB_DW'(width_reg);
        end
    end

    // Handshakes: the event buffer frees when empty or when its last event leaves
    assign m_valid  = |pend_reg;
    assign m_take   = m_valid & m_ready;
    assign buf_free = (pend_reg == 3'b000) ||
                      (m_ready && ((pend_reg & (pend_reg - 3'd1)) == 3'b000));
    assign proc_go  = in_valid_reg & buf_free;
    assign s_ready  = ~in_valid_reg | proc_go;
    assign s_take   = s_valid & s_ready;

    // Effective screen size: zero acts as one, oversize acts as the span
    always_comb begin
        if (width_reg == '0) begin
            eff_w = SIZE_BITS'(1);
        end else if (width_reg > COORD_SPAN) begin
            eff_w = COORD_SPAN;
        end else begin
            eff_w = width_reg;
        end
        if (height_reg == '0) begin
            eff_h = SIZE_BITS'(1);
        end else if (height_reg > COORD_SPAN) begin
            eff_h = COORD_SPAN;
        end else begin
            eff_h = height_reg;
        end
    end

    assign eff_w_m1 = eff_w - SIZE_BITS'(1);
    assign eff_h_m1 = eff_h - SIZE_BITS'(1);
    assign max_x    = eff_w_m1[COORD_BITS-1:0];
    assign max_y    = eff_h_m1[COORD_BITS-1:0];

    // Cursor update from the buffered second byte and the current third byte
    assign move_b1 = $signed({{(COORD_BITS-6){second_reg[7]}}, second_reg});
    assign move_b2 = $signed({{(COORD_BITS-6){in_reg.data_byte[7]}}, in_reg.data_byte});
    assign sum_x   = $signed({2'b00, pos_x_reg}) + move_b1;
    assign sum_y   = $signed({2'b00, pos_y_reg}) - move_b2;

    always_comb begin
        if (sum_x[COORD_BITS+1]) begin
            nx = '0;
        end else if (sum_x > $signed({2'b00, max_x})) begin
            nx = max_x;
        end else begin
            nx = sum_x[COORD_BITS-1:0];
        end
        if (sum_y[COORD_BITS+1]) begin
            ny = '0;
        end else if (sum_y > $signed({2'b00, max_y})) begin
            ny = max_y;
        end else begin
            ny = sum_y[COORD_BITS-1:0];
        end
    end

    assign cl = first_reg[LEFT_BIT];
    assign cr = first_reg[RIGHT_BIT];

    // Packet parser, cursor state and event buffer
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        prev_l_next = prev_l_reg;
        prev_r_next = prev_r_reg;
        kind_l_next = kind_l_reg;
        kind_r_next = kind_r_reg;
        pend_next   = m_take ? (pend_reg & (pend_reg - 3'd1)) : pend_reg;

        if (cfg_wr) begin
            // size write re-centers on both axes
            if (paddr[2] == REG_HEIGHT) begin
                height_next = pwdata[SIZE_BITS-1:0];
            end else begin
                width_next = pwdata[SIZE_BITS-1:0];
            end
            pos_x_next = eff_w[COORD_BITS:1];
            pos_y_next = eff_h[COORD_BITS:1];
            if (paddr[2] == REG_HEIGHT) begin
                if (pwdata[SIZE_BITS-1:0] == '0) begin
                    pos_y_next = '0;
                end else if (pwdata[SIZE_BITS-1:0] > COORD_SPAN) begin
                    pos_y_next = COORD_SPAN[COORD_BITS:1];
                end else begin
                    pos_y_next = pwdata[COORD_BITS:1];
                end
            end else begin
                if (pwdata[SIZE_BITS-1:0] == '0) begin
                    pos_x_next = '0;
                end else if (pwdata[SIZE_BITS-1:0] > COORD_SPAN) begin
                    pos_x_next = COORD_SPAN[COORD_BITS:1];
                end else begin
                    pos_x_next = pwdata[COORD_BITS:1];
                end
            end
        end else if (proc_go && in_reg.aux_flag) begin
            unique case (phase_reg)
                PH_SECOND: begin
                    second_next = in_reg.data_byte;
                    phase_next  = PH_THIRD;
                end
                PH_THIRD: begin
                    phase_next  = PH_FIRST;
                    pos_x_next  = nx;
                    pos_y_next  = ny;
                    prev_l_next = cl;
                    prev_r_next = cr;
                    kind_l_next = cl ? EV_DOWN : EV_UP;
                    kind_r_next = cr ? EV_DOWN : EV_UP;
                    pend_next   = {cr != prev_r_reg, cl != prev_l_reg,
                                   (nx != pos_x_reg) || (ny != pos_y_reg)};
                end
                default: begin
                    // header byte: needs the sync bit and no overflow
                    if (in_reg.data_byte[SYNC_BIT] &&
                        ((in_reg.data_byte & OVF_MASK) == 8'h00)) begin
                        first_next = in_reg.data_byte;
                        phase_next = PH_SECOND;
                    end else begin
                        phase_next = PH_FIRST;
                    end
                end
            endcase
        end
    end

    // Result item: lowest pending event goes first
    always_comb begin
        m_item.cursor_x   = pos_x_reg;
        m_item.cursor_y   = pos_y_reg;
        m_item.last_event = (pend_reg & (pend_reg - 3'd1)) == 3'b000;
        if (pend_reg[0]) begin
            m_item.event_kind   = EV_MOVE;
            m_item.which_button = BTN_LEFT;
        end else if (pend_reg[1]) begin
            m_item.event_kind   = kind_l_reg;
            m_item.which_button = BTN_LEFT;
        end else begin
            m_item.event_kind   = kind_r_reg;
            m_item.which_button = BTN_RIGHT;
        end
    end

    // Input register payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_item;
        end
    end

    // Second-byte and event-kind payload
    always_ff @(posedge aclk) begin
        second_reg <= second_next;
        kind_l_reg <= kind_l_next;
        kind_r_reg <= kind_r_next;
    end

    // Control and cursor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            width_reg    <= RESET_WIDTH;
            height_reg   <= RESET_HEIGHT;
            phase_reg    <= PH_FIRST;
            first_reg    <= '0;
            pos_x_reg    <= RESET_POS_X;
            pos_y_reg    <= RESET_POS_Y;
            prev_l_reg   <= 1'b0;
            prev_r_reg   <= 1'b0;
            pend_reg     <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (proc_go) begin
                in_valid_reg <= 1'b0;
            end
            width_reg  <= width_next;
            height_reg <= height_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            prev_l_reg <= prev_l_next;
            prev_r_reg <= prev_r_next;
            pend_reg   <= pend_next;
        end
    end

endmodule
